>>> rtl/tlff_pkg.sv
// Package for the text line format filter.
// Holds the configuration and command types, character codes and register indexes.
// No dependencies.
package tlff_pkg;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_SQUEEZE_BLANK    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUMBER_NONBLANK  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NL        = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_DOLLAR    = 8'd36;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] CH_CARET     = 8'd94;
    localparam logic [7:0] CH_TAB_SHOWN = 8'd73;
    localparam logic [7:0] CTRL_LIMIT   = 8'd32;
    localparam logic [7:0] CH_DEL       = 8'd127;
    localparam logic [7:0] CARET_OFS    = 8'd64;

    // The line counter never goes past six decimal nines.
    localparam int CNT_CAP_DIGITS = 6;

    // Entries between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic squeeze_blank;
        logic number_all;
        logic number_nonblank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // One classified request: what the back has to write for it.
    typedef struct packed {
        logic       prefix;   // number field or blank padding, then a tab
        logic       dollar;
        logic       caret;
        logic       dropped;
        logic [7:0] data;     // final byte
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

endpackage

>>> rtl/tlff_queue.sv
// Small request queue between the front and the back of the text line format filter.
// Depends on tlff_pkg for its depth.
module tlff_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(tlff_pkg::QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [tlff_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W:0]    r_count;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == (PTR_W+1)'(tlff_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/tlff_front.sv
// Front of the text line format filter: takes input bytes, keeps the line state
// and the decimal line counter, and turns each byte into one request for the back.
// Depends on tlff_pkg.
module tlff_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tlff_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    input  logic [7:0]                 i_data,
    input  logic                       i_file_start,
    input  logic                       i_room,
    output logic                       o_ready,
    output logic                       o_push,
    output tlff_pkg::t_cmd             o_cmd,
    output logic [NUMBER_DIGITS*8-1:0] o_digits
);

    localparam int CNT_DIGITS = (NUMBER_DIGITS < tlff_pkg::CNT_CAP_DIGITS) ?
                                NUMBER_DIGITS : tlff_pkg::CNT_CAP_DIGITS;

    // Line counter in BCD, digit 0 is the least significant.
    logic [3:0] r_cnt [NUMBER_DIGITS];
    logic [3:0] n_cnt [NUMBER_DIGITS];
    logic [3:0] base  [NUMBER_DIGITS];
    logic       r_prev_nl;
    logic       r_blank;

    logic       accept;
    logic       prev_nl;
    logic       blank;
    logic       cur_nl;
    logic       squeeze;
    logic       do_num;
    logic       do_pad;
    logic       sat;
    logic       carry;
    logic       nz;
    logic [3:0] dig;
    logic [7:0] cc;
    logic       caret;

    assign accept  = i_valid && i_room;
    assign o_ready = i_room;
    assign o_push  = accept;

    always_comb begin
        prev_nl = i_file_start || r_prev_nl;
        blank   = !i_file_start && r_blank;
        cur_nl  = (i_data == tlff_pkg::CH_NL);
        squeeze = i_cfg.squeeze_blank && prev_nl && cur_nl && blank;
        do_num  = prev_nl && ((i_cfg.number_all && !i_cfg.number_nonblank) ||
                              (i_cfg.number_nonblank && !cur_nl));
        do_pad  = i_cfg.show_ends && cur_nl && i_cfg.number_nonblank && prev_nl;

        // Counter: start of file clears it, then a numbered line bumps it unless
        // it already sits at its ceiling.
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            base[i] = i_file_start ? 4'd0 : r_cnt[i];
        end
        sat = 1'b1;
        for (int i = 0; i < CNT_DIGITS; i++) begin
            sat = sat && (base[i] == 4'd9);
        end
        carry = do_num && !sat;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (base[i] == 4'd9) begin
                    n_cnt[i] = 4'd0;
                end else begin
                    n_cnt[i] = base[i] + 4'd1;
                    carry    = 1'b0;
                end
            end else begin
                n_cnt[i] = base[i];
            end
        end

        // Prefix characters, most significant first; leading zeros become spaces.
        nz  = 1'b0;
        dig = 4'd0;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            dig = n_cnt[NUMBER_DIGITS-1-k];
            nz  = nz || (dig != 4'd0);
            if (do_pad) begin
                o_digits[k*8 +: 8] = tlff_pkg::CH_SPACE;
            end else if (nz || (k == NUMBER_DIGITS-1)) begin
                o_digits[k*8 +: 8] = tlff_pkg::CH_ZERO + {4'd0, dig};
            end else begin
                o_digits[k*8 +: 8] = tlff_pkg::CH_SPACE;
            end
        end

        // Caret forms for the byte itself.
        cc    = i_data;
        caret = 1'b0;
        if (i_cfg.show_tabs && (cc == tlff_pkg::CH_TAB)) begin
            caret = 1'b1;
            cc    = tlff_pkg::CH_TAB_SHOWN;
        end
        if (i_cfg.show_nonprinting && (cc != tlff_pkg::CH_NL) &&
            (cc != tlff_pkg::CH_TAB)) begin
            if (cc < tlff_pkg::CTRL_LIMIT) begin
                caret = 1'b1;
                cc    = cc + tlff_pkg::CARET_OFS;
            end else if (cc >= tlff_pkg::CH_DEL) begin
                caret = 1'b1;
                cc    = cc - tlff_pkg::CARET_OFS;
            end
        end

        if (squeeze) begin
            o_cmd.prefix  = 1'b0;
            o_cmd.dollar  = 1'b0;
            o_cmd.caret   = 1'b0;
            o_cmd.dropped = 1'b1;
            o_cmd.data    = 8'd0;
        end else begin
            o_cmd.prefix  = do_num || do_pad;
            o_cmd.dollar  = i_cfg.show_ends && cur_nl;
            o_cmd.caret   = caret;
            o_cmd.dropped = 1'b0;
            o_cmd.data    = cc;
        end
    end

    // A squeezed byte leaves the line state alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl <= 1'b1;
            r_blank   <= 1'b0;
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                r_cnt[i] <= 4'd0;
            end
        end else if (accept && !squeeze) begin
            r_prev_nl <= cur_nl;
            r_blank   <= prev_nl && cur_nl;
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

endmodule

>>> rtl/tlff_back.sv
// Back of the text line format filter: walks the output bytes of each queued
// request, one byte per cycle while the output is ready, into a registered
// output stage. Depends on tlff_pkg.
module tlff_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  tlff_pkg::t_cmd             i_cmd,
    input  logic [NUMBER_DIGITS*8-1:0] i_digits,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_data,
    output logic                       o_last,
    output logic                       o_user
);

    localparam int STEP_W  = $clog2(NUMBER_DIGITS + 3);
    localparam int PFX_LEN = NUMBER_DIGITS + 1;

    logic              r_valid;
    logic [7:0]        r_data;
    logic              r_last;
    logic              r_user;
    logic [STEP_W-1:0] r_step;

    logic [STEP_W-1:0] pfx_len;
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] rel;
    logic [STEP_W-1:0] dollar_w;
    logic [7:0]        digit_sel;
    logic [7:0]        n_data;
    logic              advance;
    logic              load;
    logic              at_last;

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

    always_comb begin
        pfx_len   = i_cmd.prefix ? STEP_W'(PFX_LEN) : '0;
        dollar_w  = {{(STEP_W-1){1'b0}}, i_cmd.dollar};
        last_step = pfx_len + dollar_w + {{(STEP_W-1){1'b0}}, i_cmd.caret};
        rel       = r_step - pfx_len;
        at_last   = (r_step == last_step);

        digit_sel = tlff_pkg::CH_SPACE;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (r_step == STEP_W'(k)) begin
                digit_sel = i_digits[k*8 +: 8];
            end
        end

        priority if (i_cmd.prefix && (r_step < STEP_W'(NUMBER_DIGITS))) begin
            n_data = digit_sel;
        end else if (i_cmd.prefix && (r_step == STEP_W'(NUMBER_DIGITS))) begin
            n_data = tlff_pkg::CH_TAB;
        end else if (i_cmd.dollar && (rel == '0)) begin
            n_data = tlff_pkg::CH_DOLLAR;
        end else if (i_cmd.caret && (rel == dollar_w)) begin
            n_data = tlff_pkg::CH_CARET;
        end else begin
            n_data = i_cmd.data;
        end

        advance = !r_valid || i_ready;
        load    = advance && !i_empty;
        o_pop   = load && at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (advance) begin
                r_valid <= !i_empty;
            end
            if (load) begin
                r_step <= at_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_last <= at_last;
            r_user <= i_cmd.dropped;
        end
    end

endmodule

>>> rtl/text_line_format_filter.sv
// Top level of the text line format filter: configuration registers, front,
// request queue and back. Depends on tlff_pkg, tlff_front, tlff_queue, tlff_back.
//
//   Channel   Direction  tdata              tuser         tlast
//   s_axis    in         in_byte [7:0]      file_start    -
//   m_axis    out        out_byte [7:0]     dropped       last
//   cfg       in         wdata[0] at addr   -             -
//
// Each input request yields 1 to NUMBER_DIGITS + 3 output bytes; the back
// writes one output byte per cycle while the output is ready (one byte for
// most requests, at least NUMBER_DIGITS + 2 for a numbered line start).
// The front accepts one byte per cycle while the four-entry queue has room.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled output holds its byte while the front keeps filling the queue.
module text_line_format_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [tlff_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [0:0]                      i_cfg_wdata,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] in_byte
    input  logic                            i_s_axis_tuser,   // [0] file_start
    // Output stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [7:0]                      o_m_axis_tdata,   // [7:0] out_byte
    output logic                            o_m_axis_tlast,
    output logic                            o_m_axis_tuser    // [0] dropped
);

    localparam int Q_W = tlff_pkg::CMD_W + NUMBER_DIGITS*8;

    tlff_pkg::t_cfg             r_cfg;
    tlff_pkg::t_cmd             front_cmd;
    tlff_pkg::t_cmd             back_cmd;
    logic [NUMBER_DIGITS*8-1:0] front_digits;
    logic [NUMBER_DIGITS*8-1:0] back_digits;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tlff_pkg::REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_wdata[0];
                tlff_pkg::REG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_wdata[0];
                tlff_pkg::REG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_wdata[0];
                tlff_pkg::REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_wdata[0];
                tlff_pkg::REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_wdata[0];
                tlff_pkg::REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    tlff_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .i_data       (i_s_axis_tdata),
        .i_file_start (i_s_axis_tuser),
        .i_room       (!q_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .o_digits     (front_digits)
    );

    tlff_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_digits, front_cmd}),
        .i_pop   (pop),
        .o_data  ({back_digits, back_cmd}),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tlff_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (back_cmd),
        .i_digits (back_digits),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .o_user   (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    // An accepted request is in the queue on the following cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !q_empty)
        else $error("accepted request missing from queue");

    // A squeezed byte is a lone, empty result.
    a_dropped_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tlast && (o_m_axis_tdata == 8'd0)))
        else $error("dropped result is not a single empty byte");

    // The queue is never popped while empty.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

    // Nothing leaves right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
